// ===== design/composite_body_inertia_merge_macros.svh =====
// assertion macros for the composite body inertia merge
`ifndef COMPOSITE_BODY_INERTIA_MERGE_MACROS_SVH
`define COMPOSITE_BODY_INERTIA_MERGE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CBIM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbim assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define CBIM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbim assertion failed");

`endif

// ===== design/cbim_pkg.sv =====
// shared types, constants and helpers of the composite body inertia merge
package cbim_pkg;

  localparam int unsigned MassW  = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned InerW  = 40;
  localparam int unsigned TotW   = MassW + 1;
  localparam int unsigned DiffW  = PosW + 1;
  localparam int unsigned ProdW  = MassW + DiffW;
  localparam int unsigned SumW   = 64;
  localparam int unsigned DataW  = MassW + 3 * PosW + 6 * InerW;
  localparam int unsigned DivSteps = DiffW;

  localparam logic signed [SumW-1:0] I40Max = 64'sd549755813887;
  localparam logic signed [SumW-1:0] I40Min = -64'sd549755813888;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       div_mul;
    logic       div_init;
    logic       div_step;
    logic       div_end;
    logic       prep_d;
    logic       t_a;
    logic       t_b;
    logic       t_c;
    logic       t_d;
    logic       commit;
    logic [1:0] axis;
    logic       part;
    logic [2:0] term;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic err;
    logic out_busy;
  } status_t;

  // first axis of a term: squares then cross pairs
  function automatic logic [1:0] pair_a(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd0;
      3'd4: r = 2'd0;
      3'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd1;
      3'd4: r = 2'd2;
      3'd5: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // inertia entries (xx xy xz yy yz zz) that a term feeds
  function automatic logic [5:0] term_mask(input logic [2:0] j);
    logic [5:0] r;
    case (j)
      3'd0: r = 6'b101000;
      3'd1: r = 6'b100001;
      3'd2: r = 6'b001001;
      3'd3: r = 6'b000010;
      3'd4: r = 6'b000100;
      3'd5: r = 6'b010000;
      default: r = 6'b000000;
    endcase
    return r;
  endfunction

  function automatic logic [InerW-1:0] sat40(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    if (v > I40Max) r = I40Max;
    else if (v < I40Min) r = I40Min;
    else r = v;
    return r[InerW-1:0];
  endfunction

endpackage

// ===== design/cbim_ctrl.sv =====
// sequencer of the composite body inertia merge
module cbim_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  cbim_pkg::status_t status_i,
  output cbim_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StLoad  = 4'd1;
  localparam logic [3:0] StDMul  = 4'd2;
  localparam logic [3:0] StDInit = 4'd3;
  localparam logic [3:0] StDStep = 4'd4;
  localparam logic [3:0] StDEnd  = 4'd5;
  localparam logic [3:0] StPrepD = 4'd6;
  localparam logic [3:0] StTA    = 4'd7;
  localparam logic [3:0] StTB    = 4'd8;
  localparam logic [3:0] StTC    = 4'd9;
  localparam logic [3:0] StTD    = 4'd10;
  localparam logic [3:0] StCommit = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [5:0] step_q, step_d;
  logic [2:0] term_q, term_d;
  logic       part_q, part_d;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    term_d  = term_q;
    part_d  = part_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    cmd_o.part = part_q;
    cmd_o.term = term_q;
    unique case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        axis_d = 2'd0;
        if (status_i.start || status_i.err) state_d = StCommit;
        else state_d = StDMul;
      end
      StDMul: begin
        cmd_o.div_mul = 1'b1;
        state_d = StDInit;
      end
      StDInit: begin
        cmd_o.div_init = 1'b1;
        step_d = '0;
        state_d = StDStep;
      end
      StDStep: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'(cbim_pkg::DivSteps - 1)) state_d = StDEnd;
      end
      StDEnd: begin
        cmd_o.div_end = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = StPrepD;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = StDMul;
        end
      end
      StPrepD: begin
        cmd_o.prep_d = 1'b1;
        term_d = '0;
        part_d = 1'b0;
        state_d = StTA;
      end
      StTA: begin
        cmd_o.t_a = 1'b1;
        state_d = StTB;
      end
      StTB: begin
        cmd_o.t_b = 1'b1;
        state_d = StTC;
      end
      StTC: begin
        cmd_o.t_c = 1'b1;
        state_d = StTD;
      end
      StTD: begin
        cmd_o.t_d = 1'b1;
        state_d = StTA;
        if (term_q == 3'd5) begin
          term_d = '0;
          part_d = 1'b1;
          if (part_q) state_d = StCommit;
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      StCommit: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign s_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= '0;
      step_q  <= '0;
      term_q  <= '0;
      part_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
      term_q  <= term_d;
      part_q  <= part_d;
    end
  end

endmodule

// ===== design/cbim_datapath.sv =====
// composite state, shared multiplier, divider and output register
module cbim_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cbim_pkg::cmd_t               cmd_i,
  output cbim_pkg::status_t            status_o,
  input  logic [cbim_pkg::DataW-1:0]  in_data_i,
  input  logic                        in_start_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [cbim_pkg::DataW-1:0]  out_data_o,
  output logic                        out_err_o
);

  localparam int unsigned MW = cbim_pkg::MassW;
  localparam int unsigned PW = cbim_pkg::PosW;
  localparam int unsigned IW = cbim_pkg::InerW;
  localparam int unsigned TW = cbim_pkg::TotW;
  localparam int unsigned DW = cbim_pkg::DiffW;
  localparam int unsigned XW = cbim_pkg::ProdW;
  localparam int unsigned SW = cbim_pkg::SumW;

  logic                 start_q;
  logic [MW-1:0]        m2_q;
  logic signed [PW-1:0] p2_q [3];
  logic [IW-1:0]        i2_q [6];
  logic [TW-1:0]        total_q;
  logic                 err_q;
  logic signed [PW-1:0] c_q [3];
  logic                 dneg_q [2][3];
  logic [PW-1:0]        dmag_q [2][3];
  logic [XW-1:0]        mul_q;
  logic [31:0]          uhi_q;
  logic [63:0]          lo_q;
  logic [TW-1:0]        rem_q;
  logic [DW-1:0]        nlo_q;
  logic [DW-1:0]        quo_q;
  logic [MW-1:0]        acc_mass_q;
  logic signed [PW-1:0] acc_pos_q [3];
  logic [IW-1:0]        acc_ine_q [6];
  logic signed [SW-1:0] s_q [6];
  logic                 out_valid_q;
  logic [cbim_pkg::DataW-1:0] out_data_q;
  logic                 out_err_q;

  logic [TW-1:0]        total_d;
  logic                 err_d;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_mag;
  logic [MW-1:0]        mul_a;
  logic [DW-1:0]        mul_b;
  logic [XW-1:0]        mul_p;
  logic [XW:0]          num;
  logic [TW:0]          rem2;
  logic                 ge;
  logic [TW:0]          rem_sub;
  logic signed [DW:0]   c_ext;
  logic [1:0]           ka, kb;
  logic [MW-1:0]        m_part;
  logic [63:0]          hi;
  logic [56:0]          r_mag;
  logic signed [SW-1:0] r_add;
  logic [5:0]           tmask;
  logic                 t_neg;
  logic [MW-1:0]        mass_n;
  logic [PW-1:0]        pos_n [3];
  logic [IW-1:0]        ine_n [6];

  always_comb begin
    total_d = {1'b0, acc_mass_q} + {1'b0, m2_q};
    err_d   = start_q ? (m2_q == '0) : (total_d == '0);
    diff    = {p2_q[cmd_i.axis][PW-1], p2_q[cmd_i.axis]}
            - {acc_pos_q[cmd_i.axis][PW-1], acc_pos_q[cmd_i.axis]};
    diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
    ka = cbim_pkg::pair_a(cmd_i.term);
    kb = cbim_pkg::pair_b(cmd_i.term);
    m_part = cmd_i.part ? m2_q : acc_mass_q;
    if (cmd_i.div_mul) begin
      mul_a = m2_q;
      mul_b = diff_mag;
    end else if (cmd_i.t_a) begin
      mul_a = dmag_q[cmd_i.part][ka];
      mul_b = {1'b0, dmag_q[cmd_i.part][kb]};
    end else if (cmd_i.t_b) begin
      mul_a = m_part;
      mul_b = {1'b0, mul_q[31:0]};
    end else begin
      mul_a = m_part;
      mul_b = {1'b0, uhi_q};
    end
    mul_p = mul_a * mul_b;
    num   = {1'b0, mul_q} + {{(XW-TW+2){1'b0}}, total_q[TW-1:1]};
    rem2  = {rem_q, nlo_q[DW-1]};
    ge    = rem2 >= {1'b0, total_q};
    rem_sub = rem2 - {1'b0, total_q};
    c_ext = diff[DW-1] ? ({{2{acc_pos_q[cmd_i.axis][PW-1]}}, acc_pos_q[cmd_i.axis]}
                          - $signed({1'b0, quo_q}))
                       : ({{2{acc_pos_q[cmd_i.axis][PW-1]}}, acc_pos_q[cmd_i.axis]}
                          + $signed({1'b0, quo_q}));
    hi    = mul_q[63:0] + {32'd0, lo_q[63:32]};
    r_mag = {1'b0, hi[63:8]} + {56'd0, hi[7]};
    tmask = cbim_pkg::term_mask(cmd_i.term);
    t_neg = dneg_q[cmd_i.part][ka] ^ dneg_q[cmd_i.part][kb];
    if (cmd_i.term < 3'd3 || t_neg) r_add = $signed({7'd0, r_mag});
    else r_add = -$signed({7'd0, r_mag});
    if (start_q) begin
      mass_n = m2_q;
      for (int i = 0; i < 3; i++) pos_n[i] = err_q ? '0 : p2_q[i];
      for (int i = 0; i < 6; i++) ine_n[i] = i2_q[i];
    end else begin
      mass_n = total_q[TW-1] ? '1 : total_q[MW-1:0];
      for (int i = 0; i < 3; i++) pos_n[i] = c_q[i];
      for (int i = 0; i < 6; i++) ine_n[i] = cbim_pkg::sat40(s_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      start_q <= in_start_i;
      m2_q    <= in_data_i[MW-1:0];
      for (int i = 0; i < 3; i++) p2_q[i] <= in_data_i[MW + i*PW +: PW];
      for (int i = 0; i < 6; i++) i2_q[i] <= in_data_i[MW + 3*PW + i*IW +: IW];
    end
    if (cmd_i.load) begin
      total_q <= total_d;
      err_q   <= err_d;
      for (int i = 0; i < 3; i++) c_q[i] <= '0;
      for (int i = 0; i < 6; i++) begin
        s_q[i] <= SW'($signed(acc_ine_q[i])) + SW'($signed(i2_q[i]));
      end
    end
    if (cmd_i.div_mul || cmd_i.t_a || cmd_i.t_b || cmd_i.t_c) mul_q <= mul_p;
    if (cmd_i.t_b) uhi_q <= mul_q[63:32];
    if (cmd_i.t_c) lo_q <= mul_q[63:0];
    if (cmd_i.div_init) begin
      rem_q <= num[XW:DW];
      nlo_q <= num[DW-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[TW-1:0] : rem2[TW-1:0];
      nlo_q <= {nlo_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], ge};
    end
    if (cmd_i.div_end) c_q[cmd_i.axis] <= c_ext[PW-1:0];
    if (cmd_i.prep_d) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [DW-1:0] d1, d2;
        d1 = {c_q[i][PW-1], c_q[i]} - {acc_pos_q[i][PW-1], acc_pos_q[i]};
        d2 = {c_q[i][PW-1], c_q[i]} - {p2_q[i][PW-1], p2_q[i]};
        dneg_q[0][i] <= d1[DW-1];
        dneg_q[1][i] <= d2[DW-1];
        dmag_q[0][i] <= d1[DW-1] ? PW'(-d1) : PW'(d1);
        dmag_q[1][i] <= d2[DW-1] ? PW'(-d2) : PW'(d2);
      end
    end
    if (cmd_i.t_d) begin
      for (int i = 0; i < 6; i++) begin
        if (tmask[i]) s_q[i] <= s_q[i] + r_add;
      end
    end
    if (cmd_i.commit) begin
      out_data_q <= {ine_n[5], ine_n[4], ine_n[3], ine_n[2], ine_n[1], ine_n[0],
                     pos_n[2], pos_n[1], pos_n[0], mass_n};
      out_err_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_mass_q  <= '0;
      for (int i = 0; i < 3; i++) acc_pos_q[i] <= '0;
      for (int i = 0; i < 6; i++) acc_ine_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        acc_mass_q <= mass_n;
        for (int i = 0; i < 3; i++) acc_pos_q[i] <= pos_n[i];
        for (int i = 0; i < 6; i++) acc_ine_q[i] <= ine_n[i];
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.start    = start_q;
  assign status_o.err      = err_d;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_err_o   = out_err_q;

endmodule

// ===== design/composite_body_inertia_merge.sv =====
// top level of the composite rigid body inertia merge
// keeps one composite body; a start request replaces it, a merge request adds
// the body to it by the parallel axis theorem; one result per input request
// s_axis: tuser is the start flag, tdata mass, centre and own inertia
// m_axis: tuser is the zero mass flag, tdata the updated composite
// a start request, or a merge whose total mass is zero, goes from accept
// through the load and commit states to the output register, and the input
// is ready again in the same cycle as the result shows; a merge request
// passes the load state, a bit-serial divider that forms each of the three
// centre coordinates, a prep state, one shared 32x33 multiplier that builds
// the twelve parallel axis terms through the states TA, TB, TC, TD, then commit
// the next request is accepted once the result sits in the output register
// a result held by a stalled receiver blocks only the commit of the next one
// reset clears the composite to zero mass, zero centre and zero inertia
module composite_body_inertia_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // mass, pos_x, pos_y, pos_z, ixx, ixy, ixz, iyy, iyz, izz
  input  logic [cbim_pkg::DataW-1:0] s_axis_tdata_i,
  // start_req
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // merged mass, pos_x, pos_y, pos_z, ixx, ixy, ixz, iyy, iyz, izz
  output logic [cbim_pkg::DataW-1:0] m_axis_tdata_o,
  // zero_mass_error
  output logic                       m_axis_tuser_o
);

  cbim_pkg::cmd_t    cmd;
  cbim_pkg::status_t status;

  cbim_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cbim_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .in_start_i  (s_axis_tuser_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule

// ===== design/cbim_checker.sv =====
// port-level checks of the composite body inertia merge
`include "composite_body_inertia_merge_macros.svh"

module cbim_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_valid_i,
  input logic                       s_ready_i,
  input logic                       m_valid_i,
  input logic                       m_ready_i,
  input logic [cbim_pkg::DataW-1:0] m_data_i,
  input logic                       m_err_i
);

  `CBIM_ASSERT_NXT(a_out_hold, m_valid_i && !m_ready_i, m_valid_i && $stable(m_data_i))
  `CBIM_ASSERT_IMP(a_err_mass, m_valid_i, m_err_i == (m_data_i[31:0] == 32'd0))
  `CBIM_ASSERT_IMP(a_err_centre, m_valid_i && m_err_i, m_data_i[127:32] == 96'd0)
  `CBIM_ASSERT_NXT(a_one_busy, s_valid_i && s_ready_i, !s_ready_i)

endmodule

bind composite_body_inertia_merge cbim_checker u_cbim_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid_i),
  .s_ready_i (s_axis_tready_o),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o),
  .m_err_i   (m_axis_tuser_o)
);

// ===== bench/composite_body_inertia_merge_tb.sv =====
// testbench for the composite body inertia merge: scoreboard prediction of each request
`timescale 1ns / 100ps

class inertia_scoreboard;
  bit [31:0] comp_mass;
  bit signed [63:0] comp_pos[3];
  bit signed [63:0] comp_iner[6];
  bit [367:0] want_data[$];
  bit want_err[$];
  int errors;
  int checked;

  function new();
    comp_mass = 0;
    foreach (comp_pos[i]) comp_pos[i] = 0;
    foreach (comp_iner[i]) comp_iner[i] = 0;
    errors = 0;
    checked = 0;
  endfunction

  static function bit [63:0] magn(bit signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  static function bit signed [63:0] axis_prod(bit [63:0] m, bit signed [63:0] da,
                                             bit signed [63:0] db);
    bit [63:0] u;
    bit [127:0] p;
    bit [63:0] r;
    u = magn(da) * magn(db);
    p = 128'(m) * 128'(u);
    r = 64'(p >> 40) + 64'((p >> 39) & 1);
    return ((da < 0) != (db < 0)) ? -$signed(r) : $signed(r);
  endfunction

  static function bit signed [63:0] shift_term(bit [63:0] m, bit signed [63:0] d[3], int e);
    int a;
    int b;
    bit signed [63:0] s;
    a = (e < 3) ? 0 : (e < 5 ? 1 : 2);
    b = (e == 0) ? 0 : (e == 1 || e == 3) ? 1 : 2;
    s = 0;
    if (a != b) return -axis_prod(m, d[a], d[b]);
    for (int k = 0; k < 3; k++) if (k != a) s += axis_prod(m, d[k], d[k]);
    return s;
  endfunction

  function void note_request(bit start, bit [367:0] din);
    bit [63:0] m2;
    bit [63:0] m1;
    bit [63:0] tot;
    bit [63:0] q;
    bit signed [63:0] p2[3];
    bit signed [63:0] i2[6];
    bit signed [63:0] c[3];
    bit signed [63:0] d1[3];
    bit signed [63:0] d2[3];
    bit signed [63:0] diff;
    bit signed [63:0] s;
    bit err;
    bit [367:0] dout;
    m2 = din[31:0];
    for (int i = 0; i < 3; i++) p2[i] = $signed(din[32+32*i +: 32]);
    for (int i = 0; i < 6; i++) i2[i] = $signed(din[128+40*i +: 40]);
    if (start) begin
      tot = m2;
      err = (m2 == 0);
      for (int i = 0; i < 3; i++) comp_pos[i] = err ? 0 : p2[i];
      for (int i = 0; i < 6; i++) comp_iner[i] = i2[i];
    end else begin
      m1 = comp_mass;
      tot = m1 + m2;
      err = (tot == 0);
      for (int i = 0; i < 3; i++) begin
        if (err) begin
          c[i] = 0;
        end else begin
          diff = p2[i] - comp_pos[i];
          q = (m2 * magn(diff) + (tot >> 1)) / tot;
          c[i] = diff < 0 ? comp_pos[i] - $signed(q) : comp_pos[i] + $signed(q);
        end
        d1[i] = c[i] - comp_pos[i];
        d2[i] = c[i] - p2[i];
      end
      for (int i = 0; i < 6; i++) begin
        s = comp_iner[i] + i2[i];
        if (!err) s += shift_term(m1, d1, i) + shift_term(m2, d2, i);
        if (s > 64'sd549755813887) s = 64'sd549755813887;
        if (s < -64'sd549755813888) s = -64'sd549755813888;
        comp_iner[i] = s;
      end
      for (int i = 0; i < 3; i++) comp_pos[i] = c[i];
    end
    comp_mass = tot > 64'hFFFFFFFF ? 32'hFFFFFFFF : tot[31:0];
    dout[31:0] = comp_mass;
    for (int i = 0; i < 3; i++) dout[32+32*i +: 32] = comp_pos[i][31:0];
    for (int i = 0; i < 6; i++) dout[128+40*i +: 40] = comp_iner[i][39:0];
    want_data.push_back(dout);
    want_err.push_back(err);
  endfunction

  function void check_result(bit [367:0] dout, bit err);
    bit [367:0] wd;
    bit we;
    if (want_data.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h err %0d", dout, err);
      return;
    end
    wd = want_data.pop_front();
    we = want_err.pop_front();
    checked++;
    if (wd !== dout || we !== err) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch at result %0d", checked);
        $display("  expected %h err %0d", wd, we);
        $display("  actual   %h err %0d", dout, err);
      end
    end
  endfunction
endclass

module composite_body_inertia_merge_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [cbim_pkg::DataW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [cbim_pkg::DataW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  inertia_scoreboard merge_sb = new();
  int n_start;
  int n_merge;
  bit rx_on;

  always #2 clk_i = ~clk_i;

  composite_body_inertia_merge DUT (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  function automatic logic [31:0] rnd_pos(bit narrow);
    logic [31:0] v;
    v = $urandom;
    if (narrow) v = {{6{v[25]}}, v[25:0]};
    return v;
  endfunction

  function automatic logic [39:0] rnd_iner(bit narrow);
    logic [39:0] v;
    v = 40'({$urandom, $urandom});
    if (narrow) v = {{8{v[31]}}, v[31:0]};
    return v;
  endfunction

  task automatic send_body(bit start, logic [cbim_pkg::DataW-1:0] d);
    int g;
    g = gap_len();
    repeat (g + 1) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= start;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    merge_sb.note_request(start, d);
    if (start) n_start++;
    else n_merge++;
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic send_rand(bit start, int shape);
    logic [cbim_pkg::DataW-1:0] d;
    bit nar;
    nar = (shape != 0);
    d[31:0] = $urandom;
    if (shape == 1) d[31:0] = $urandom_range(0, 32'h00FF_FFFF);
    if (shape == 2) d[31:0] = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) d[32+32*i +: 32] = rnd_pos(nar);
    for (int i = 0; i < 6; i++) d[128+40*i +: 40] = rnd_iner(nar);
    send_body(start, d);
  endtask

  task automatic drain();
    while (merge_sb.want_data.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) merge_sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  initial begin
    int g;
    while (1) begin
      @(posedge clk_i);
      if (!rx_on) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= 1'b0;
          repeat (g) @(posedge clk_i);
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic [cbim_pkg::DataW-1:0] d;
    rx_on = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero merge, extremes, zero mass start, mass overflow
    send_body(1'b0, '0);
    d = '1;
    send_body(1'b1, d);
    send_body(1'b0, d);
    d = '0;
    d[31:0] = 32'hFFFF_FFFF;
    for (int i = 0; i < 3; i++) d[32+32*i +: 32] = 32'h8000_0000;
    for (int i = 0; i < 6; i++) d[128+40*i +: 40] = 40'h80_0000_0000;
    send_body(1'b1, d);
    for (int i = 0; i < 3; i++) d[32+32*i +: 32] = 32'h7FFF_FFFF;
    for (int i = 0; i < 6; i++) d[128+40*i +: 40] = 40'h7F_FFFF_FFFF;
    send_body(1'b0, d);
    d[31:0] = 32'h0;
    send_body(1'b1, d);
    send_body(1'b0, d);
    d[31:0] = 32'h0001_0000;
    send_body(1'b0, d);
    for (int i = 0; i < 3; i++) d[32+32*i +: 32] = 32'h0100_0000 << i;
    for (int i = 0; i < 6; i++) d[128+40*i +: 40] = 40'h1_0000_0000;
    send_body(1'b1, d);
    for (int i = 0; i < 3; i++) d[32+32*i +: 32] = -(32'h0100_0000 << i);
    send_body(1'b0, d);
    d[31:0] = 32'h0000_0001;
    send_body(1'b0, d);
    drain();
    rx_on = 1'b1;
    for (int n = 0; n < 1440; n++) begin
      send_rand(($urandom_range(0, 9) == 0), $urandom_range(0, 2));
      if (n == 700) drain();
    end
    drain();
    $display("covered %0d start and %0d merge requests, %0d results checked",
             n_start, n_merge, merge_sb.checked);
    if (merge_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", merge_sb.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/cbim_pkg.sv
design/cbim_ctrl.sv
design/cbim_datapath.sv
design/composite_body_inertia_merge.sv
design/cbim_checker.sv
bench/composite_body_inertia_merge_tb.sv
